// File: src/cpd_pkg.sv
// Shared types and constants for the click peak detector.
// No dependencies.
package cpd_pkg;

  localparam int SEGMENT_LEN_DEF = 4096;
  localparam int MAX_CLICKS_DEF  = 63;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int CLICK_CNT_W     = 6;
  localparam int CLICK_IDX_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_POWER_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NBD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WIN   = 3'd4;

  typedef enum logic [2:0] {
    F_LOAD, F_SETUP, F_SCAN, F_CHK, F_WAIT, F_SUM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_RUN, B_WAIT, B_DEC
  } back_state_t;

  // back to front status
  typedef struct packed {
    logic                   idle;
    logic                   click_ovf;
    logic [CLICK_CNT_W-1:0] clicks;
  } back_status_t;

endpackage

// File: src/click_peak_detector.sv
// Top level of the click peak detector: config registers, sample stores, output stage.
// Depends on cpd_pkg, cpd_ram, cpd_queue, cpd_front, cpd_back.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------------
//  sample in | start, busy               | power_value, ratio_value, last
//  config    | cfg_we                    | cfg_index, cfg_data
//  result    | result_valid (one cycle)  | click_index, is_summary, click_count,
//            |                           | overflow, last_result
//
// Loading: one sample transfer per cycle while busy is low.
// After the last sample busy rises: the scan reads each sample from the power
// store, then compares it; each click start adds a back-end ratio search,
// which reads one ratio per cycle (none when the search window is empty).
// Busy drops in the same cycle as the summary transfer. rst is synchronous and
// clears all control state; the sample stores are not cleared.
// Results cannot be stalled: each strobe lasts one cycle.
module click_peak_detector #(
  parameter int SEGMENT_LEN = cpd_pkg::SEGMENT_LEN_DEF,
  parameter int MAX_CLICKS  = cpd_pkg::MAX_CLICKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] power_value,
  input  logic [31:0] ratio_value,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic        result_valid,
  output logic [cpd_pkg::CLICK_IDX_W-1:0] click_index,
  output logic        is_summary,
  output logic [cpd_pkg::CLICK_CNT_W-1:0] click_count,
  output logic        overflow,
  output logic        last_result
);
  localparam int AW = $clog2(SEGMENT_LEN);
  localparam int CW = AW + 1;
  localparam int SW = ((CW > 13) ? CW : 13) + 2;

  // configuration registers
  logic [31:0] power_threshold, ratio_threshold;
  logic [12:0] refractory_len, avg_window;
  logic [11:0] neighbourhood_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_threshold   <= '0;
      ratio_threshold   <= '0;
      refractory_len    <= '0;
      neighbourhood_len <= '0;
      avg_window        <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cpd_pkg::REG_POWER_THR: power_threshold   <= cfg_data;
        cpd_pkg::REG_RATIO_THR: ratio_threshold   <= cfg_data;
        cpd_pkg::REG_REFRACT:   refractory_len    <= cfg_data[12:0];
        cpd_pkg::REG_NBD:       neighbourhood_len <= cfg_data[11:0];
        cpd_pkg::REG_AVG_WIN:   avg_window        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic                 wr_en;
  logic [AW-1:0]        wr_addr, p_raddr, r_raddr;
  logic [31:0]          p_rdata, r_rdata;
  logic                 push, pop, q_empty, q_full;
  logic [SW-1:0]        push_pos, q_data;
  logic                 reply_valid;
  logic signed [SW-1:0] reply_pos, shift, nscan;
  logic                 sum_valid, sample_ovf, click_valid;
  logic [cpd_pkg::CLICK_IDX_W-1:0] click_idx_b;
  cpd_pkg::back_status_t bstat;

  cpd_ram #(.WIDTH(32), .DEPTH(SEGMENT_LEN)) u_power_store (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(power_value),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  cpd_ram #(.WIDTH(32), .DEPTH(SEGMENT_LEN)) u_ratio_store (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(ratio_value),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  cpd_front #(.SEGMENT_LEN(SEGMENT_LEN), .AW(AW), .CW(CW), .SW(SW)) u_front (
    .clk, .rst, .start, .last, .busy,
    .power_threshold, .refractory_len, .avg_window,
    .wr_en, .wr_addr, .p_raddr, .p_rdata,
    .push, .push_pos, .q_full, .q_empty,
    .reply_valid, .reply_pos, .bstat,
    .shift, .nscan, .sum_valid, .sample_ovf
  );

  cpd_queue #(.W(SW)) u_queue (
    .clk, .rst, .push, .push_data(push_pos), .pop, .pop_data(q_data),
    .empty(q_empty), .full(q_full)
  );

  cpd_back #(.SEGMENT_LEN(SEGMENT_LEN), .MAX_CLICKS(MAX_CLICKS), .AW(AW), .SW(SW)) u_back (
    .clk, .rst, .ratio_threshold, .neighbourhood_len, .shift, .nscan,
    .q_empty, .q_data, .pop, .r_raddr, .r_rdata,
    .reply_valid, .reply_pos, .click_valid, .click_index(click_idx_b),
    .seg_clear(sum_valid), .bstat
  );

  // output stage: click items from the back end, summary from the front end
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= click_valid || sum_valid;
    end
    click_index <= sum_valid ? '0 : click_idx_b;
    is_summary  <= sum_valid;
    last_result <= sum_valid;
    click_count <= sum_valid ? bstat.clicks : '0;
    overflow    <= sum_valid && (sample_ovf || bstat.click_ovf);
  end

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    !(click_valid && sum_valid)) else $error("click and summary together");
  a_click_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_summary) |-> busy) else $error("click result while idle");
  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_summary) |-> !busy) else $error("busy after summary");
endmodule

// File: src/cpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/cpd_queue.sv
// Two-entry queue of click-start positions between front and back.
// No dependencies.
module cpd_queue #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = entry[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// File: src/cpd_front.sv
// Front: loads samples, scans power values for click starts, emits summary.
// Depends on cpd_pkg.
module cpd_front #(
  parameter int SEGMENT_LEN = cpd_pkg::SEGMENT_LEN_DEF,
  parameter int AW = $clog2(SEGMENT_LEN),
  parameter int CW = $clog2(SEGMENT_LEN) + 1,
  parameter int SW = ((CW > 13) ? CW : 13) + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last,
  output logic                 busy,
  input  logic [31:0]          power_threshold,
  input  logic [12:0]          refractory_len,
  input  logic [12:0]          avg_window,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [AW-1:0]        p_raddr,
  input  logic [31:0]          p_rdata,
  output logic                 push,
  output logic [SW-1:0]        push_pos,
  input  logic                 q_full,
  input  logic                 q_empty,
  input  logic                 reply_valid,
  input  logic signed [SW-1:0] reply_pos,
  input  cpd_pkg::back_status_t bstat,
  output logic signed [SW-1:0] shift,
  output logic signed [SW-1:0] nscan,
  output logic                 sum_valid,
  output logic                 sample_ovf
);
  cpd_pkg::front_state_t state, state_next;
  logic [CW-1:0]         count;
  logic [12:0]           quiet;
  logic signed [SW-1:0]  pos;
  logic                  accept;
  logic                  has_room;
  logic [12:0]           avg_eff;
  logic                  is_quiet;

  assign accept   = start && !busy;
  assign has_room = count < CW'(SEGMENT_LEN);
  assign avg_eff  = (avg_window == 13'd0) ? 13'd1 : avg_window;
  assign is_quiet = p_rdata <= power_threshold;
  assign wr_en    = accept && has_room;
  assign wr_addr  = count[AW-1:0];
  assign p_raddr  = pos[AW-1:0];
  assign push_pos = pos;

  always_comb begin
    state_next = state;
    case (state)
      cpd_pkg::F_LOAD:  if (accept && last) state_next = cpd_pkg::F_SETUP;
      cpd_pkg::F_SETUP: state_next = cpd_pkg::F_SCAN;
      cpd_pkg::F_SCAN:  state_next = (pos < nscan) ? cpd_pkg::F_CHK : cpd_pkg::F_SUM;
      cpd_pkg::F_CHK: begin
        if (is_quiet || quiet < refractory_len) begin
          state_next = cpd_pkg::F_SCAN;
        end else if (!q_full) begin
          state_next = cpd_pkg::F_WAIT;
        end
      end
      cpd_pkg::F_WAIT:  if (reply_valid) state_next = cpd_pkg::F_SCAN;
      cpd_pkg::F_SUM:   state_next = cpd_pkg::F_LOAD;
      default:          state_next = cpd_pkg::F_LOAD;
    endcase
  end

  always_comb begin
    busy      = (state != cpd_pkg::F_LOAD);
    sum_valid = (state == cpd_pkg::F_SUM);
    push      = (state == cpd_pkg::F_CHK) && !is_quiet &&
                (quiet >= refractory_len) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cpd_pkg::F_LOAD;
      count      <= '0;
      sample_ovf <= 1'b0;
      quiet      <= '0;
      pos        <= '0;
      shift      <= '0;
      nscan      <= '0;
    end else begin
      state <= state_next;
      case (state)
        cpd_pkg::F_LOAD: begin
          if (accept) begin
            if (has_room) count <= count + CW'(1);
            else          sample_ovf <= 1'b1;
          end
        end
        cpd_pkg::F_SETUP: begin
          shift <= $signed(SW'(avg_eff >> 1));
          nscan <= $signed(SW'(count)) - $signed(SW'(avg_eff)) + SW'(1);
          quiet <= '0;
          pos   <= '0;
        end
        cpd_pkg::F_CHK: begin
          if (is_quiet) begin
            if (quiet != 13'h1FFF) quiet <= quiet + 13'd1;
            pos <= pos + SW'(1);
          end else if (quiet < refractory_len) begin
            quiet <= '0;
            pos   <= pos + SW'(1);
          end else if (!q_full) begin
            quiet <= '0;
          end
        end
        cpd_pkg::F_WAIT: if (reply_valid) pos <= reply_pos + SW'(1);
        cpd_pkg::F_SUM: begin
          count      <= '0;
          sample_ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // summary only once the back end has drained
  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (q_empty && bstat.idle)) else $error("summary while back busy");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("push into full queue");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == cpd_pkg::F_CHK) |-> (pos >= 0)) else $error("negative scan position");
endmodule

// File: src/cpd_back.sv
// Back: peak ratio search around each click start, click emission.
// Depends on cpd_pkg.
module cpd_back #(
  parameter int SEGMENT_LEN = cpd_pkg::SEGMENT_LEN_DEF,
  parameter int MAX_CLICKS  = cpd_pkg::MAX_CLICKS_DEF,
  parameter int AW = $clog2(SEGMENT_LEN),
  parameter int SW = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           ratio_threshold,
  input  logic [11:0]           neighbourhood_len,
  input  logic signed [SW-1:0]  shift,
  input  logic signed [SW-1:0]  nscan,
  input  logic                  q_empty,
  input  logic [SW-1:0]         q_data,
  output logic                  pop,
  output logic [AW-1:0]         r_raddr,
  input  logic [31:0]           r_rdata,
  output logic                  reply_valid,
  output logic signed [SW-1:0]  reply_pos,
  output logic                  click_valid,
  output logic [cpd_pkg::CLICK_IDX_W-1:0] click_index,
  input  logic                  seg_clear,
  output cpd_pkg::back_status_t bstat
);
  cpd_pkg::back_state_t state, state_next;
  logic signed [SW-1:0] ti, lo, hi, j, best;
  logic signed [SW-1:0] c_pos, lo_c, hi_c, best_back, best_fwd;
  logic [31:0]          best_val;
  logic                 first, rd_v, rd_last;
  logic signed [SW-1:0] rd_idx;
  logic [cpd_pkg::CLICK_CNT_W-1:0] clicks;
  logic                 click_ovf;
  logic                 is_click, has_room;

  assign c_pos     = ti - shift;
  assign best_back = best - shift;
  assign best_fwd  = best + shift;
  assign is_click  = best_val > ratio_threshold;
  assign has_room  = clicks < cpd_pkg::CLICK_CNT_W'(MAX_CLICKS);
  assign r_raddr   = j[AW-1:0];
  assign bstat     = '{idle: (state == cpd_pkg::B_IDLE), click_ovf: click_ovf, clicks: clicks};

  always_comb begin
    lo_c = c_pos - $signed(SW'(neighbourhood_len));
    hi_c = c_pos + $signed(SW'(neighbourhood_len)) + SW'(1);
    if (lo_c < 0)     lo_c = '0;
    if (hi_c > nscan) hi_c = nscan;
  end

  always_comb begin
    state_next = state;
    case (state)
      cpd_pkg::B_IDLE:  if (!q_empty) state_next = cpd_pkg::B_SETUP;
      cpd_pkg::B_SETUP: state_next = (hi_c > lo_c) ? cpd_pkg::B_RUN : cpd_pkg::B_IDLE;
      cpd_pkg::B_RUN:   if (j == hi - SW'(1)) state_next = cpd_pkg::B_WAIT;
      cpd_pkg::B_WAIT:  state_next = cpd_pkg::B_DEC;
      cpd_pkg::B_DEC:   state_next = cpd_pkg::B_IDLE;
      default:          state_next = cpd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop         = (state == cpd_pkg::B_IDLE) && !q_empty;
    reply_valid = 1'b0;
    reply_pos   = ti;
    click_valid = 1'b0;
    click_index = best_fwd[cpd_pkg::CLICK_IDX_W-1:0];
    case (state)
      cpd_pkg::B_SETUP: reply_valid = !(hi_c > lo_c);
      cpd_pkg::B_DEC: begin
        reply_valid = 1'b1;
        click_valid = is_click && has_room;
        if (is_click && best_back > ti) reply_pos = best_back;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpd_pkg::B_IDLE;
      clicks    <= '0;
      click_ovf <= 1'b0;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      first     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_v    <= (state == cpd_pkg::B_RUN);
      rd_last <= (state == cpd_pkg::B_RUN) && (j == hi - SW'(1));
      rd_idx  <= j;
      if (rd_v && (first || r_rdata > best_val)) begin
        best_val <= r_rdata;
        best     <= rd_idx;
        first    <= 1'b0;
      end
      case (state)
        cpd_pkg::B_IDLE:  if (!q_empty) ti <= $signed(q_data);
        cpd_pkg::B_SETUP: begin
          lo    <= lo_c;
          hi    <= hi_c;
          j     <= lo_c;
          first <= 1'b1;
        end
        cpd_pkg::B_RUN:   j <= j + SW'(1);
        cpd_pkg::B_DEC: begin
          if (is_click) begin
            if (has_room) clicks <= clicks + cpd_pkg::CLICK_CNT_W'(1);
            else          click_ovf <= 1'b1;
          end
        end
        default: ;
      endcase
      if (seg_clear) begin
        clicks    <= '0;
        click_ovf <= 1'b0;
      end
    end
  end

  a_rd_window: assert property (@(posedge clk) disable iff (rst)
    (state == cpd_pkg::B_RUN) |-> (j >= lo && j < hi)) else $error("read outside window");
  a_dec_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == cpd_pkg::B_DEC) |-> $past(rd_last)) else $error("decision before last read");
  a_click_cap: assert property (@(posedge clk) disable iff (rst)
    click_valid |-> has_room) else $error("click over capacity");
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for click_peak_detector: loads sample segments, predicts
// the click and summary transfers in the bench itself and compares them.
// Depends on cpd_pkg and the click_peak_detector RTL.
module tb_top;

  localparam int SEG_DEPTH   = 4096;
  localparam int CLICK_LIMIT = 63;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [cpd_pkg::CLICK_IDX_W-1:0] idx;
    logic                            summ;
    logic [cpd_pkg::CLICK_CNT_W-1:0] cnt;
    logic                            ovf;
    logic                            fin;
  } click_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] power_value = '0;
  logic [31:0] ratio_value = '0;
  logic last = 1'b0;
  logic cfg_we = 1'b0;
  logic [cpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic result_valid;
  logic [cpd_pkg::CLICK_IDX_W-1:0] click_index;
  logic is_summary;
  logic [cpd_pkg::CLICK_CNT_W-1:0] click_count;
  logic overflow;
  logic last_result;

  click_peak_detector u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .power_value(power_value), .ratio_value(ratio_value), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .click_index(click_index),
    .is_summary(is_summary), .click_count(click_count),
    .overflow(overflow), .last_result(last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench copy of the detector: config, segment stores, expected transfers.
  logic [31:0] thr_power, thr_ratio;
  logic [12:0] refract_len;
  logic [11:0] half_nbd;
  logic [12:0] avg_win;
  logic [31:0] pwr_mem [SEG_DEPTH];
  logic [31:0] rat_mem [SEG_DEPTH];
  int          seg_fill;
  bit          seg_dropped;
  click_rec_t  click_q [$];
  int          fail_cnt = 0;
  longint      cycle_cnt = 0;

  // sender burst pacing
  bit bursty = 1'b1;
  int burst_left = 0;

  task automatic detect_clicks();
    int a, sh, nscan, nbd, pos, i, c, lo, hi, best, j;
    int quiet, clicks;
    bit ovf;
    click_rec_t r;
    ovf   = seg_dropped;
    a     = (avg_win == 0) ? 1 : int'(avg_win);
    sh    = a / 2;
    nscan = seg_fill - (a - 1);
    nbd   = int'(half_nbd);
    quiet = 0;
    clicks = 0;
    pos   = 0;
    while (pos < nscan) begin
      i = pos;
      if (pwr_mem[i] <= thr_power) begin
        if (quiet < 8191) quiet++;
      end else begin
        if (quiet >= int'(refract_len)) begin
          // peak search centered half a window back, clipped to scanned range
          c  = i - sh;
          lo = c - nbd;
          hi = c + nbd + 1;
          if (lo < 0) lo = 0;
          if (hi > nscan) hi = nscan;
          if (hi > lo) begin
            best = lo;
            for (j = lo + 1; j < hi; j++)
              if (rat_mem[j] > rat_mem[best]) best = j;
            if (rat_mem[best] > thr_ratio) begin
              if (clicks < CLICK_LIMIT) begin
                r = '0;
                r.idx = cpd_pkg::CLICK_IDX_W'(best + sh);
                click_q.push_back(r);
                clicks++;
              end else begin
                ovf = 1'b1;
              end
              if (best - sh > i) pos = best - sh;
            end
          end
        end
        quiet = 0;
      end
      pos++;
    end
    r = '0;
    r.summ = 1'b1;
    r.cnt  = cpd_pkg::CLICK_CNT_W'(clicks);
    r.ovf  = ovf;
    r.fin  = 1'b1;
    click_q.push_back(r);
    seg_fill = 0;
    seg_dropped = 1'b0;
  endtask

  task automatic record_sample(logic [31:0] p, logic [31:0] q, logic l);
    if (seg_fill < SEG_DEPTH) begin
      pwr_mem[seg_fill] = p;
      rat_mem[seg_fill] = q;
      seg_fill++;
    end else begin
      seg_dropped = 1'b1;
    end
    if (l) detect_clicks();
  endtask

  // One sample transfer; start stays high on return so a following send
  // does not have to re-raise it in the same step.
  task automatic send_sample(logic [31:0] p, logic [31:0] q, logic l);
    if (bursty) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    start       <= 1'b1;
    power_value <= p;
    ratio_value <= q;
    last        <= l;
    do @(posedge clk); while (busy);
    record_sample(p, q, l);
  endtask

  // Pause the sender until every expected transfer has come and the
  // block is idle again.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (click_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] pt, logic [31:0] rt, logic [12:0] rf,
                            logic [11:0] nb, logic [12:0] aw);
    logic [31:0] vals [5];
    logic [cpd_pkg::CFG_IDX_W-1:0] regs [5];
    vals = '{pt, rt, 32'(rf), 32'(nb), 32'(aw)};
    regs = '{cpd_pkg::REG_POWER_THR, cpd_pkg::REG_RATIO_THR, cpd_pkg::REG_REFRACT,
             cpd_pkg::REG_NBD, cpd_pkg::REG_AVG_WIN};
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    thr_power = pt;
    thr_ratio = rt;
    refract_len = rf;
    half_nbd = nb;
    avg_win = aw;
    @(posedge clk);
  endtask

  // result checker: the receiver cannot stall, so every strobe is a transfer
  always @(posedge clk) begin
    click_rec_t got, want;
    if (!rst && result_valid) begin
      got = '{click_index, is_summary, click_count, overflow, last_result};
      if (click_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_cnt++;
      end else begin
        want = click_q.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: click_index expected %0d actual %0d", $time, want.idx, got.idx);
          fail_cnt++;
        end
        if (got.summ !== want.summ) begin
          $display("%0t: is_summary expected %0b actual %0b", $time, want.summ, got.summ);
          fail_cnt++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: click_count expected %0d actual %0d", $time, want.cnt, got.cnt);
          fail_cnt++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
          fail_cnt++;
        end
        if (got.fin !== want.fin) begin
          $display("%0t: last_result expected %0b actual %0b", $time, want.fin, got.fin);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** click_peak_detector: FAILED **");
      $finish;
    end
  end

  // reset values of the registers, extreme field values
  task automatic test_defaults();
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    drain();
  endtask

  // all-ones thresholds: nothing can exceed them
  task automatic test_max_thresholds();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd4096, 12'd0, 13'd1);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();
  endtask

  // widest search window; ties resolve to the first peak
  task automatic test_wide_window();
    set_config(32'h0001_0000, 32'h0000_8000, 13'd0, 12'd4095, 13'd2);
    send_sample(32'h0, 32'h0002_0000, 1'b0);
    send_sample(32'h0, 32'h0005_0000, 1'b0);
    send_sample(32'h0002_0000, 32'h0001_0000, 1'b0);
    send_sample(32'h0, 32'h0005_0000, 1'b0);
    send_sample(32'h0003_0000, 32'h0, 1'b1);
    drain();
  endtask

  // short segment with a window longer than the segment, then a zero window (acts as one)
  task automatic test_short_and_zero_window();
    set_config(32'h0, 32'h0, 13'd0, 12'd1, 13'd4096);
    for (int k = 0; k < 5; k++) send_sample($urandom, $urandom, k == 4);
    drain();
    set_config(32'h0, 32'h0, 13'd1, 12'd1, 13'd0);
    for (int k = 0; k < 6; k++) send_sample($urandom, $urandom, k == 5);
    drain();
  endtask

  // shifted window falls before index zero: the start yields no click
  task automatic test_empty_window();
    set_config(32'h10, 32'h0, 13'd0, 12'd0, 13'd8);
    for (int k = 0; k < 10; k++)
      send_sample(k == 0 ? 32'hFFFF : 32'h0, 32'hFFFF, k == 9);
    drain();
  endtask

  // every sample a click: only the first 63 are reported
  task automatic test_click_overflow();
    set_config(32'h0, 32'h0, 13'd0, 12'd0, 13'd1);
    for (int k = 0; k < 70; k++) send_sample(32'h1 + k, 32'h100 + k, k == 69);
    drain();
  endtask

  // random configurations and well-formed segments with random content
  task automatic test_random_segments();
    int sent, seg_len;
    logic [31:0] pt, p;
    sent = 0;
    while (sent < 260) begin
      pt = $urandom;
      set_config(pt, $urandom, 13'($urandom_range(0, 6)), 12'($urandom_range(0, 8)),
                 13'($urandom_range(0, 8)));
      bursty = ($urandom_range(0, 3) != 0);
      for (int s = 0; s < 3; s++) begin
        seg_len = $urandom_range(1, 40);
        for (int k = 0; k < seg_len; k++) begin
          p = $urandom_range(0, 1) ? $urandom : $urandom_range(0, pt);
          send_sample(p, $urandom, k == seg_len - 1);
        end
        sent += seg_len;
      end
      bursty = 1'b1;
      drain();
    end
  endtask

  initial begin
    thr_power = '0;
    thr_ratio = '0;
    refract_len = '0;
    half_nbd = '0;
    avg_win = 13'd1;
    seg_fill = 0;
    seg_dropped = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_max_thresholds();
    test_wide_window();
    test_short_and_zero_window();
    test_empty_window();
    test_click_overflow();
    test_random_segments();
    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && click_q.size() == 0) begin
      $display("** click_peak_detector: PASSED **");
    end else begin
      $display("** click_peak_detector: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cpd_pkg.sv
src/cpd_ram.sv
src/cpd_queue.sv
src/cpd_front.sv
src/cpd_back.sv
src/click_peak_detector.sv
bench/tb_top.sv
